>>> rtl/core/tts_pkg.sv
// Shared types, constants and the arctangent table for the twist to steer/speed unit.
package tts_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;

    localparam int VEL_W  = 16;
    localparam int WB_W   = 16;
    localparam int ANG_W  = 16;
    localparam int Y0_W   = 31;
    localparam int XY_W   = 34;
    localparam int Z_W    = 33;
    localparam int ATAN_W = 30;
    localparam int INV_W  = 30;
    localparam int PROD_W = 63;
    localparam int AQ_W   = 15;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_BASE_LEN     = 2'd0;
    localparam logic [IDX_W-1:0] REG_STEER_OFFSET = 2'd1;

    localparam logic [WB_W-1:0]   BASE_LEN_RST   = 16'd4096;
    localparam logic [INV_W-1:0]  INV_GAIN_Q30   = 30'd652032874;
    localparam logic [Z_W-1:0]    LIMIT_155_Q30  = 33'd1664299827;
    localparam logic [AQ_W-1:0]   HALF_PI_Q13    = 15'd12868;

    localparam logic [ATAN_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
        30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
        30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
        30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
    };

    // Rotation state of one CORDIC step.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // Per-request facts carried alongside the rotation.
    typedef struct packed {
        logic signed [VEL_W-1:0] v;
        logic [Y0_W-1:0]         y0;
        logic                    v_neg;
        logic                    w_neg;
        logic                    w_zero;
        logic                    v_zero;
        logic                    y_zero;
    } side_t;

endpackage

>>> rtl/core/tts_cordic_stage.sv
// One registered CORDIC vectoring stage with its valid bit and side information.
module tts_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  tts_pkg::cordic_t   in_cor,
    input  tts_pkg::side_t     in_side,
    output logic               out_valid,
    output tts_pkg::cordic_t   out_cor,
    output tts_pkg::side_t     out_side
);

    logic               valid_reg;
    tts_pkg::cordic_t   cor_reg;
    tts_pkg::cordic_t   cor_next;
    tts_pkg::side_t     side_reg;

    always_comb begin
        logic signed [tts_pkg::XY_W-1:0] dx;
        logic signed [tts_pkg::XY_W-1:0] dy;
        logic signed [tts_pkg::Z_W-1:0]  da;
        dx = in_cor.y >>> SHIFT;
        dy = in_cor.x >>> SHIFT;
        da = signed'({{(tts_pkg::Z_W-tts_pkg::ATAN_W){1'b0}}, tts_pkg::ATAN_TAB[SHIFT]});
        // Rotate toward the x axis: the sign of y picks the direction.
        if (!in_cor.y[tts_pkg::XY_W-1]) begin
            cor_next.x = in_cor.x + dx;
            cor_next.y = in_cor.y - dy;
            cor_next.z = in_cor.z + da;
        end else begin
            cor_next.x = in_cor.x - dx;
            cor_next.y = in_cor.y + dy;
            cor_next.z = in_cor.z - da;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cor_reg  <= cor_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_cor   = cor_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/core/twist_to_steer_speed_unit.sv
// Top level: converts a body twist into a front-wheel steering angle and drive speed.
//
// Requests arrive on the s_ channel (linear velocity and yaw rate, Q7.8) with
// valid/ready; results leave on the m_ channel (steering angle Q2.13, wheel
// speed Q7.8, saturation flag) in request order, one result per request.
// The configuration port writes the wheelbase (index 0) and steer_offset (index 1)
// and should only be used while no request is in flight.
// The pipeline has CORDIC_STAGES + 3 register stages (the stage count is capped
// at 24): one entry stage with the L*|w| multiply, one stage per CORDIC
// iteration, one stage for the gain multiply, one output register.
// Throughput is one request per cycle while the receiver keeps m_ready high; the unrolled CORDIC chain sets it.
// Every stage carries its own valid bit and holds only when it is full and the
// stage after it holds, so a stalled receiver stops the pipeline from the
// output back, while empty stages further up keep taking requests.
// Reset empties the pipeline and restores the wheelbase to 1.0 m and the offset
// to zero.
module twist_to_steer_speed_unit #(
    parameter int CORDIC_STAGES = tts_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tts_pkg::IDX_W-1:0]          cfg_addr,
    input  logic [15:0]                        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [tts_pkg::VEL_W-1:0]   s_linear_velocity,
    input  logic signed [tts_pkg::VEL_W-1:0]   s_yaw_rate,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [tts_pkg::ANG_W-1:0]   m_steering_angle,
    output logic signed [tts_pkg::VEL_W-1:0]   m_wheel_speed,
    output logic                               m_saturated
);

    localparam int N = (CORDIC_STAGES > tts_pkg::TABLE_LEN) ? tts_pkg::TABLE_LEN
                                                             : CORDIC_STAGES;
    localparam int P = N + 3;

    // Configuration registers.
    logic [tts_pkg::WB_W-1:0]         base_len_reg;
    logic signed [tts_pkg::ANG_W-1:0] steer_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg     <= tts_pkg::BASE_LEN_RST;
            steer_offset_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tts_pkg::REG_BASE_LEN:     base_len_reg     <= cfg_wdata;
                tts_pkg::REG_STEER_OFFSET: steer_offset_reg <= signed'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Stage valid bits and load enables, last stage first.
    logic [P-1:0] vld;
    logic [P-1:0] en;

    always_comb begin
        en[P-1] = !vld[P-1] || m_ready;
        for (int k = P - 2; k >= 0; k--) begin
            en[k] = !vld[k] || en[k+1];
        end
    end

    assign s_ready = en[0];

    // Entry stage: magnitudes, L*|w| and special-case flags.
    tts_pkg::cordic_t cor [N+1];
    tts_pkg::side_t   side [N+1];
    logic             a_valid_reg;
    tts_pkg::cordic_t a_cor_reg;
    tts_pkg::side_t   a_side_reg;
    tts_pkg::cordic_t a_cor_next;
    tts_pkg::side_t   a_side_next;

    always_comb begin
        logic [tts_pkg::VEL_W-1:0] av;
        logic [tts_pkg::VEL_W-1:0] aw;
        logic [31:0]               prod;
        av   = s_linear_velocity[tts_pkg::VEL_W-1] ? 16'(-s_linear_velocity)
                                                   : 16'(s_linear_velocity);
        aw   = s_yaw_rate[tts_pkg::VEL_W-1] ? 16'(-s_yaw_rate) : 16'(s_yaw_rate);
        prod = base_len_reg * aw;
        a_cor_next.x = signed'({6'd0, av, 12'd0});
        a_cor_next.y = signed'({3'd0, prod[tts_pkg::Y0_W-1:0]});
        a_cor_next.z = '0;
        a_side_next.v      = s_linear_velocity;
        a_side_next.y0     = prod[tts_pkg::Y0_W-1:0];
        a_side_next.v_neg  = s_linear_velocity[tts_pkg::VEL_W-1];
        a_side_next.w_neg  = s_yaw_rate[tts_pkg::VEL_W-1];
        a_side_next.w_zero = (s_yaw_rate == '0);
        a_side_next.v_zero = (s_linear_velocity == '0);
        a_side_next.y_zero = (s_yaw_rate == '0) || (base_len_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en[0]) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_cor_reg  <= a_cor_next;
            a_side_reg <= a_side_next;
        end
    end

    assign vld[0]  = a_valid_reg;
    assign cor[0]  = a_cor_reg;
    assign side[0] = a_side_reg;

    // CORDIC chain.
    for (genvar i = 0; i < N; i++) begin : g_cordic
        tts_cordic_stage #(
            .SHIFT (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en[i+1]),
            .in_valid  (vld[i]),
            .in_cor    (cor[i]),
            .in_side   (side[i]),
            .out_valid (vld[i+1]),
            .out_cor   (cor[i+1]),
            .out_side  (side[i+1])
        );
    end

    // Gain stage: clamp, magnitude times 1/K, rounded angle, large-angle test.
    logic                         g_valid_reg;
    logic [tts_pkg::PROD_W-1:0]   g_prod_reg;
    logic [tts_pkg::AQ_W-1:0]     g_ang_reg;
    logic                         g_large_reg;
    tts_pkg::side_t               g_side_reg;
    logic [tts_pkg::PROD_W-1:0]   g_prod_next;
    logic [tts_pkg::AQ_W-1:0]     g_ang_next;
    logic                         g_large_next;

    always_comb begin
        logic [tts_pkg::Z_W-1:0]    zc;
        logic [tts_pkg::XY_W-2:0]   xc;
        logic [tts_pkg::Z_W-1:0]    zr;
        zc = cor[N].z[tts_pkg::Z_W-1] ? '0 : unsigned'(cor[N].z);
        xc = cor[N].x[tts_pkg::XY_W-1] ? '0 : cor[N].x[tts_pkg::XY_W-2:0];
        zr = zc + 33'd65536;
        g_ang_next   = zr[17 +: tts_pkg::AQ_W];
        g_large_next = zc > tts_pkg::LIMIT_155_Q30;
        g_prod_next  = xc * tts_pkg::INV_GAIN_Q30;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en[N+1]) begin
            g_valid_reg <= vld[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[N+1]) begin
            g_prod_reg  <= g_prod_next;
            g_ang_reg   <= g_ang_next;
            g_large_reg <= g_large_next;
            g_side_reg  <= side[N];
        end
    end

    assign vld[N+1] = g_valid_reg;

    // Output stage: special cases, signs, offset and saturation.
    logic                             m_valid_reg;
    logic signed [tts_pkg::ANG_W-1:0] ang_reg;
    logic signed [tts_pkg::VEL_W-1:0] spd_reg;
    logic                             sat_reg;
    logic signed [tts_pkg::ANG_W-1:0] ang_next;
    logic signed [tts_pkg::VEL_W-1:0] spd_next;
    logic                             sat_next;

    always_comb begin
        logic [tts_pkg::AQ_W-1:0]   mag;
        logic                       big_ang;
        logic [31:0]                lw_sum;
        logic [tts_pkg::PROD_W:0]   m_sum;
        logic signed [23:0]         mag_spd;
        logic signed [23:0]         speed;
        logic signed [16:0]         angle;
        logic signed [17:0]         diff;
        tts_pkg::side_t             sd;
        sd     = g_side_reg;
        lw_sum = {1'b0, sd.y0} + 32'd2048;
        m_sum  = {1'b0, g_prod_reg} + (64'd1 << 41);
        if (sd.v_zero) begin
            mag     = tts_pkg::HALF_PI_Q13;
            big_ang = 1'b1;
        end else if (sd.y_zero) begin
            mag     = '0;
            big_ang = 1'b0;
        end else begin
            mag     = g_ang_reg;
            big_ang = g_large_reg;
        end
        if (big_ang) begin
            mag_spd = signed'({4'd0, lw_sum[31:12]});
        end else begin
            mag_spd = signed'({2'd0, m_sum[63:42]});
        end
        if (sd.w_zero) begin
            speed = 24'(sd.v);
            angle = '0;
        end else begin
            if (!big_ang && sd.y_zero) begin
                speed = 24'(sd.v);
            end else begin
                speed = sd.v_neg ? -mag_spd : mag_spd;
            end
            angle = sd.w_neg ? -signed'({2'd0, mag}) : signed'({2'd0, mag});
        end
        sat_next = 1'b0;
        if (speed > 24'sd32767) begin
            spd_next = 16'sh7FFF;
            sat_next = 1'b1;
        end else if (speed < -24'sd32768) begin
            spd_next = -16'sh8000;
            sat_next = 1'b1;
        end else begin
            spd_next = speed[15:0];
        end
        if (spd_next[tts_pkg::VEL_W-1]) begin
            angle = -angle;
        end
        diff = 18'(angle) - 18'(steer_offset_reg);
        if (diff > 18'sd32767) begin
            ang_next = 16'sh7FFF;
            sat_next = 1'b1;
        end else if (diff < -18'sd32768) begin
            ang_next = -16'sh8000;
            sat_next = 1'b1;
        end else begin
            ang_next = diff[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en[N+2]) begin
            m_valid_reg <= vld[N+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[N+2]) begin
            ang_reg <= ang_next;
            spd_reg <= spd_next;
            sat_reg <= sat_next;
        end
    end

    assign vld[N+2]         = m_valid_reg;
    assign m_valid          = m_valid_reg;
    assign m_steering_angle = ang_reg;
    assign m_wheel_speed    = spd_reg;
    assign m_saturated      = sat_reg;

endmodule
